// ===== hdl/mbrc_pkg.sv =====
package mbrc_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [3:0] verdict;
        logic [7:0] exception_code;
    } t_out_word;

    typedef logic [3:0] t_verdict;

    localparam t_verdict V_READ_OK   = 4'd0;
    localparam t_verdict V_WRITE_OK  = 4'd1;
    localparam t_verdict V_CRC       = 4'd2;
    localparam t_verdict V_STATION   = 4'd3;
    localparam t_verdict V_FUNCTION  = 4'd4;
    localparam t_verdict V_COUNT     = 4'd5;
    localparam t_verdict V_LENGTH    = 4'd6;
    localparam t_verdict V_ECHO      = 4'd7;
    localparam t_verdict V_EXCEPTION = 4'd8;

    localparam logic [1:0] REG_STATION    = 2'd0;
    localparam logic [1:0] REG_FUNCTION   = 2'd1;
    localparam logic [1:0] REG_START_ADDR = 2'd2;
    localparam logic [1:0] REG_QUANTITY   = 2'd3;

    localparam logic [7:0] FC_READ_COILS = 8'd1;
    localparam logic [7:0] FC_READ_REGS  = 8'd3;
    localparam logic [7:0] FC_WRITE_COILS = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int HDR_DEPTH = 6;

    // Reflected CRC-16/MODBUS, one byte: eight shift steps.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/modbus_rtu_response_checker_unit.sv =====
// Modbus RTU response checker.
// Input channel: one received response byte per word (rx_byte) with a flag
// on the final byte of the frame (last_byte). Output channel: one verdict
// word per frame, carrying the verdict code and, for an exception response,
// the exception code (zero otherwise).
// The request (station, function, start address, quantity) is held in four
// APB registers at byte addresses 0, 4, 8 and 12; write them only while no
// frame is in flight. pready is tied high.
// Throughput: one byte per cycle while input ready is high. The CRC step, the
// header capture and the whole verdict decision sit between the frame state
// registers and the output register.
// The verdict word is registered into the main output slot, or into the skid
// slot when the main slot is stalled.
// Stall: the output side has a main register plus a skid register, so bytes
// keep flowing while one verdict waits; input ready drops only when both
// hold an untaken verdict.
// Reset: registers return to station 1, function 3, address 0, quantity 1;
// the running CRC returns to its initial value; byte count and both output slots are cleared.
module modbus_rtu_response_checker_unit
    import mbrc_pkg::*;
#(
    parameter int MAX_FRAME = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    // verdict output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // byte count saturates at MAX_FRAME + 1
    localparam int PW = $clog2(MAX_FRAME + 2);
    localparam int CW = (PW > 9) ? PW : 9;

    // configuration registers
    logic [7:0]  r_req_station;
    logic [7:0]  r_req_function;
    logic [15:0] r_req_start_addr;
    logic [15:0] r_req_quantity;

    // frame state
    logic [15:0] r_crc;
    logic [15:0] r_crc_prev;     // CRC before the latest byte
    logic [7:0]  r_prev_byte;    // latest byte
    logic [PW-1:0] r_pos;
    logic [7:0]  r_hdr [HDR_DEPTH];

    // output slots
    logic        r_out_valid;
    t_out_word   r_out;
    logic        r_skid_valid;
    t_out_word   r_skid;

    logic        in_fire;
    logic        cfg_write;
    logic [PW-1:0] n_pos;
    logic [7:0]  n_hdr [HDR_DEPTH];
    logic [CW-1:0] len_w;
    logic [CW-1:0] b2_plus5;
    logic [16:0] want_count;
    logic        crc_ok;
    logic        exc_match;
    t_out_word   n_result;

    assign pready     = 1'b1;
    assign cfg_write  = psel & penable & pwrite;
    assign o_in_ready = ~r_skid_valid;
    assign in_fire    = i_in_valid & o_in_ready;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_station    <= 8'd1;
            r_req_function   <= 8'd3;
            r_req_start_addr <= 16'd0;
            r_req_quantity   <= 16'd1;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_STATION:    r_req_station    <= pwdata[7:0];
                REG_FUNCTION:   r_req_function   <= pwdata[7:0];
                REG_START_ADDR: r_req_start_addr <= pwdata[15:0];
                REG_QUANTITY:   r_req_quantity   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_STATION:    prdata = {24'd0, r_req_station};
            REG_FUNCTION:   prdata = {24'd0, r_req_function};
            REG_START_ADDR: prdata = {16'd0, r_req_start_addr};
            REG_QUANTITY:   prdata = {16'd0, r_req_quantity};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- per-byte next state ----------------
    always_comb begin
        n_pos = (r_pos <= PW'(MAX_FRAME)) ? r_pos + PW'(1) : r_pos;
        for (int i = 0; i < HDR_DEPTH; i++) begin
            n_hdr[i] = r_hdr[i];
            if (r_pos == PW'(i)) begin
                n_hdr[i] = i_in_data.rx_byte;
            end
        end
    end

    // ---------------- verdict decision ----------------
    always_comb begin
        len_w      = CW'(n_pos);
        b2_plus5   = CW'(n_hdr[2]) + CW'(5);
        // CRC over all but the last two bytes sits in r_crc_prev
        crc_ok     = (r_crc_prev[7:0] == r_prev_byte) &&
                     (r_crc_prev[15:8] == i_in_data.rx_byte);
        exc_match  = n_hdr[1][7] && !r_req_function[7] &&
                     (n_hdr[1][6:0] == r_req_function[6:0]);
        if (n_hdr[1] == FC_READ_COILS) begin
            want_count = {3'd0, 14'((17'(r_req_quantity) + 17'd7) >> 3)};
        end else begin
            want_count = {r_req_quantity, 1'b0};
        end

        n_result.exception_code = 8'd0;
        if (len_w < CW'(4) || len_w > CW'(MAX_FRAME)) begin
            n_result.verdict = V_LENGTH;
        end else if (!crc_ok) begin
            n_result.verdict = V_CRC;
        end else if (n_hdr[0] != r_req_station) begin
            n_result.verdict = V_STATION;
        end else if (n_hdr[1] != r_req_function) begin
            if (exc_match) begin
                n_result.verdict        = V_EXCEPTION;
                n_result.exception_code = n_hdr[2];
            end else begin
                n_result.verdict = V_FUNCTION;
            end
        end else if ((n_hdr[1] == FC_READ_COILS || n_hdr[1] == FC_READ_REGS) &&
                     (b2_plus5 == len_w)) begin
            n_result.verdict = (want_count == {9'd0, n_hdr[2]}) ? V_READ_OK : V_COUNT;
        end else if ((n_hdr[1] == FC_WRITE_COILS || n_hdr[1] == FC_WRITE_REGS) &&
                     (len_w == CW'(8))) begin
            if ({n_hdr[2], n_hdr[3]} == r_req_start_addr &&
                {n_hdr[4], n_hdr[5]} == r_req_quantity) begin
                n_result.verdict = V_WRITE_OK;
            end else begin
                n_result.verdict = V_ECHO;
            end
        end else begin
            n_result.verdict = V_LENGTH;
        end
    end

    // ---------------- frame state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_crc_prev  <= CRC_INIT;
            r_prev_byte <= 8'd0;
            r_pos       <= '0;
        end else if (in_fire) begin
            if (i_in_data.last_byte) begin
                // drop the frame state, ready for the next response
                r_crc       <= CRC_INIT;
                r_crc_prev  <= CRC_INIT;
                r_prev_byte <= 8'd0;
                r_pos       <= '0;
            end else begin
                r_crc       <= crc16_byte(r_crc, i_in_data.rx_byte);
                r_crc_prev  <= r_crc;
                r_prev_byte <= i_in_data.rx_byte;
                r_pos       <= n_pos;
            end
        end
    end

    // header bytes need no reset: only positions of the current frame are read
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int i = 0; i < HDR_DEPTH; i++) begin
                r_hdr[i] <= n_hdr[i];
            end
        end
    end

    // ---------------- output register with skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || i_out_ready) begin
                // main slot free or emptying: advance skid first, else new word
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_fire & i_in_data.last_byte;
                end
            end else if (in_fire && i_in_data.last_byte) begin
                // main slot stalled: hold the new word in the skid slot
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire && i_in_data.last_byte) begin
                r_out <= n_result;
            end
        end else if (in_fire && i_in_data.last_byte) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== test/modbus_rtu_response_checker_unit_test.sv =====
`timescale 1ns / 1ps

module modbus_rtu_response_checker_unit_test;
    import mbrc_pkg::*;

    localparam int FRAME_MAX     = 256;
    localparam int IDLE_LIMIT    = 600;
    localparam int SETTLE_CYCLES = 4;
    localparam int BYTE_GOAL     = 1600;

    // Kinds of response frame the stimulus can build against the programmed request.
    typedef enum int {
        FR_REPLY,
        FR_EXCEPTION,
        FR_WRONG_STATION,
        FR_WRONG_FUNCTION,
        FR_WRONG_COUNT,
        FR_WRONG_ECHO,
        FR_WRONG_LENGTH,
        FR_BAD_CRC,
        FR_SHORT,
        FR_NOISE,
        FR_OVERSIZE
    } t_frame_kind;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_word    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_word   out_data;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // Words waiting to be driven, and verdicts waiting to come back.
    t_in_word  byte_q [$];
    t_out_word verdict_q [$];

    int errors       = 0;
    int bytes_queued = 0;
    int idle_cycles  = 0;
    int in_gap       = 0;
    int out_stall    = 0;
    bit in_calm      = 1'b0;
    bit out_calm     = 1'b0;

    // Shadow of the request registers, updated when an APB write lands.
    logic [7:0]  cfg_station  = 8'd1;
    logic [7:0]  cfg_function = FC_READ_REGS;
    logic [15:0] cfg_start    = 16'd0;
    logic [15:0] cfg_quantity = 16'd1;

    // Frame state of the predictor; tail[0] and crc_tail[0] belong to the newest byte.
    logic [15:0] run_crc       = CRC_INIT;
    int          seen_bytes    = 0;
    logic [7:0]  head [HDR_DEPTH];
    logic [7:0]  tail [2]      = '{8'h00, 8'h00};
    logic [15:0] crc_tail [2]  = '{CRC_INIT, CRC_INIT};

    modbus_rtu_response_checker_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    // Bit-serial CRC-16/MODBUS: feed the data LSB first through the reflected polynomial.
    function automatic logic [15:0] crc_shift_byte(input logic [15:0] crc,
                                                   input logic [7:0]  data);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ data[i];
            r  = r >> 1;
            if (fb) begin
                r = r ^ 16'hA001;
            end
        end
        return r;
    endfunction

    // Decide the verdict of a finished frame of len bytes against the request.
    function automatic t_out_word judge_frame(input int len);
        t_out_word r;
        int        want;
        r = '0;
        if (len < 4 || len > FRAME_MAX) begin
            r.verdict = V_LENGTH;
        end else if (crc_tail[1][7:0] != tail[1] || crc_tail[1][15:8] != tail[0]) begin
            r.verdict = V_CRC;
        end else if (head[0] != cfg_station) begin
            r.verdict = V_STATION;
        end else if (head[1] != cfg_function) begin
            // an exception reply carries the function code with its top bit set
            if (head[1][7] && {1'b0, head[1][6:0]} == cfg_function) begin
                r.verdict        = V_EXCEPTION;
                r.exception_code = head[2];
            end else begin
                r.verdict = V_FUNCTION;
            end
        end else if ((head[1] == FC_READ_COILS || head[1] == FC_READ_REGS) &&
                     int'(head[2]) + 5 == len) begin
            want = (head[1] == FC_READ_COILS) ? (int'(cfg_quantity) + 7) / 8
                                             : int'(cfg_quantity) * 2;
            r.verdict = (want == int'(head[2])) ? V_READ_OK : V_COUNT;
        end else if ((head[1] == FC_WRITE_COILS || head[1] == FC_WRITE_REGS) && len == 8) begin
            if (head[2] == cfg_start[15:8] && head[3] == cfg_start[7:0] &&
                head[4] == cfg_quantity[15:8] && head[5] == cfg_quantity[7:0]) begin
                r.verdict = V_WRITE_OK;
            end else begin
                r.verdict = V_ECHO;
            end
        end else begin
            r.verdict = V_LENGTH;
        end
        return r;
    endfunction

    // Advance the predictor by one accepted word; queue a verdict on the last byte.
    task automatic fold_in_byte(input t_in_word w);
        if (seen_bytes < HDR_DEPTH) begin
            head[seen_bytes] = w.rx_byte;
        end
        tail[1]     = tail[0];
        tail[0]     = w.rx_byte;
        crc_tail[1] = crc_tail[0];
        crc_tail[0] = run_crc;
        run_crc     = crc_shift_byte(run_crc, w.rx_byte);
        // saturate the count one past the largest legal frame
        if (seen_bytes <= FRAME_MAX) begin
            seen_bytes++;
        end
        if (w.last_byte) begin
            verdict_q.push_back(judge_frame(seen_bytes));
            run_crc    = CRC_INIT;
            seen_bytes = 0;
            tail       = '{8'h00, 8'h00};
            crc_tail   = '{CRC_INIT, CRC_INIT};
        end
    endtask

    // Draw the wait before the next word; now and then flip into or out of a burst stretch.
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 31) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // Build one response frame of the given kind and queue its bytes.
    task automatic queue_frame(input t_frame_kind kind);
        logic [7:0]  fb [$];
        logic [7:0]  stn;
        logic [7:0]  fn;
        logic [15:0] crc;
        int          n;
        int          want;
        int          k;
        t_in_word    w;
        fb = {};
        case (kind)
            FR_SHORT: begin
                repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
            end
            FR_NOISE: begin
                repeat ($urandom_range(4, 12)) fb.push_back(8'($urandom));
            end
            FR_OVERSIZE: begin
                repeat ($urandom_range(FRAME_MAX + 1, FRAME_MAX + 40)) begin
                    fb.push_back(8'($urandom));
                end
            end
            default: begin
                stn = cfg_station;
                if (kind == FR_WRONG_STATION) begin
                    stn = stn ^ 8'($urandom_range(1, 255));
                end
                fn = cfg_function;
                if (kind == FR_EXCEPTION) begin
                    fn = cfg_function + 8'd128;
                end else if (kind == FR_WRONG_FUNCTION) begin
                    fn = fn ^ 8'($urandom_range(1, 255));
                end
                fb.push_back(stn);
                fb.push_back(fn);
                if (kind == FR_EXCEPTION) begin
                    fb.push_back(8'($urandom));
                end else if (fn == FC_READ_COILS || fn == FC_READ_REGS) begin
                    want = (fn == FC_READ_COILS) ? (int'(cfg_quantity) + 7) / 8
                                                : int'(cfg_quantity) * 2;
                    // use a random count for a wrong-count frame or when the true one cannot fit a frame
                    if (kind == FR_WRONG_COUNT || want > FRAME_MAX - 5) begin
                        n = $urandom_range(0, 30);
                    end else begin
                        n = want;
                    end
                    fb.push_back(8'(n));
                    repeat (n) fb.push_back(8'($urandom));
                end else if (fn == FC_WRITE_COILS || fn == FC_WRITE_REGS) begin
                    fb.push_back(cfg_start[15:8]);
                    fb.push_back(cfg_start[7:0]);
                    fb.push_back(cfg_quantity[15:8]);
                    fb.push_back(cfg_quantity[7:0]);
                    if (kind == FR_WRONG_ECHO) begin
                        k     = $urandom_range(2, 5);
                        fb[k] = fb[k] ^ 8'(1 << $urandom_range(0, 7));
                    end
                end else begin
                    repeat ($urandom_range(0, 6)) fb.push_back(8'($urandom));
                end
                if (kind == FR_WRONG_LENGTH) begin
                    if ($urandom_range(0, 1) == 1) begin
                        fb.push_back(8'($urandom));
                    end else begin
                        void'(fb.pop_back());
                    end
                end
                // append the CRC low byte first; spoil one bit of it for a CRC error frame
                crc = CRC_INIT;
                foreach (fb[i]) crc = crc_shift_byte(crc, fb[i]);
                if (kind == FR_BAD_CRC) begin
                    crc = crc ^ 16'(1 << $urandom_range(0, 15));
                end
                fb.push_back(crc[7:0]);
                fb.push_back(crc[15:8]);
            end
        endcase
        foreach (fb[i]) begin
            w.rx_byte   = fb[i];
            w.last_byte = (i == fb.size() - 1);
            byte_q.push_back(w);
        end
        bytes_queued += fb.size();
    endtask

    // Half well-formed replies, the rest exceptions, broken frames or noise.
    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return FR_REPLY;
        if (r < 58) return FR_EXCEPTION;
        if (r < 63) return FR_WRONG_STATION;
        if (r < 68) return FR_WRONG_FUNCTION;
        if (r < 74) return FR_WRONG_COUNT;
        if (r < 80) return FR_WRONG_ECHO;
        if (r < 86) return FR_WRONG_LENGTH;
        if (r < 93) return FR_BAD_CRC;
        if (r < 96) return FR_SHORT;
        return FR_NOISE;
    endfunction

    // APB write: setup cycle, access cycle, register lands at the access edge.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // junk above the register width must be dropped by the block
        pwdata  <= (idx == REG_STATION || idx == REG_FUNCTION) ?
                   {24'($urandom), value[7:0]} :
                   {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STATION:    cfg_station  = value[7:0];
            REG_FUNCTION:   cfg_function = value[7:0];
            REG_START_ADDR: cfg_start    = value;
            REG_QUANTITY:   cfg_quantity = value;
            default: ;
        endcase
    endtask

    task automatic program_request(input logic [7:0] stn, input logic [7:0] fn,
                                   input logic [15:0] addr, input logic [15:0] qty);
        write_reg(REG_STATION, {8'h00, stn});
        write_reg(REG_FUNCTION, {8'h00, fn});
        write_reg(REG_START_ADDR, addr);
        write_reg(REG_QUANTITY, qty);
    endtask

    // Hold until every word is taken and every verdict is back, then let the pipe drain.
    task automatic settle();
        while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Byte driver: fold the accepted word into the predictor, then present the next
    // one after its drawn gap. Valid stays up with the same word until taken.
    always @(posedge i_clk) begin
        logic hold;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            hold = in_valid;
            if (in_valid && in_ready) begin
                fold_in_byte(in_data);
                hold = 1'b0;
            end
            if (!hold) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (byte_q.size() > 0) begin
                    in_data <= byte_q.pop_front();
                    hold    = 1'b1;
                    in_gap  = draw_gap(in_calm);
                end
            end
            in_valid <= hold;
        end
    end

    // Verdict monitor: compare each taken word with the oldest prediction, then
    // stall for a drawn number of cycles before taking the next one.
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected verdict word: expected none, got verdict %0d code %0d",
                             $time, out_data.verdict, out_data.exception_code);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (out_data.verdict != want.verdict) begin
                        $display("%0t: verdict mismatch: expected %0d, got %0d",
                                 $time, want.verdict, out_data.verdict);
                        errors++;
                    end
                    if (out_data.exception_code != want.exception_code) begin
                        $display("%0t: exception code mismatch: expected %0d, got %0d",
                                 $time, want.exception_code, out_data.exception_code);
                        errors++;
                    end
                end
                out_stall = draw_gap(out_calm);
            end else if (out_stall > 0) begin
                out_stall--;
            end
            out_ready <= (out_stall == 0);
        end
    end

    // Watchdog: any handshake or register access counts as progress.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("modbus_rtu_response_checker_unit_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset request: station 1, read registers, one register.
        queue_frame(FR_REPLY);
        queue_frame(FR_EXCEPTION);
        queue_frame(FR_SHORT);
        queue_frame(FR_BAD_CRC);
        settle();

        // Lowest station, read coils with zero quantity: count byte of zero.
        program_request(8'h00, FC_READ_COILS, 16'h0000, 16'h0000);
        queue_frame(FR_REPLY);
        queue_frame(FR_WRONG_COUNT);
        settle();

        // Highest station, write registers with all-ones echo.
        program_request(8'hFF, FC_WRITE_REGS, 16'hFFFF, 16'hFFFF);
        queue_frame(FR_REPLY);
        queue_frame(FR_WRONG_ECHO);
        settle();

        program_request(8'd247, FC_WRITE_COILS, 16'h00FF, 16'hFF00);
        queue_frame(FR_REPLY);
        queue_frame(FR_WRONG_STATION);
        settle();

        // Longest legal frame (251 data bytes) on either side of a frame past the size limit.
        program_request(8'd17, FC_READ_COILS, 16'h1234, 16'd2008);
        queue_frame(FR_REPLY);
        queue_frame(FR_OVERSIZE);
        queue_frame(FR_REPLY);
        settle();

        // Function codes at the edges: exception bytes 0x80 and 0xFF, and one
        // whose exception form cannot exist.
        program_request(8'd2, 8'h00, 16'h0001, 16'd1);
        queue_frame(FR_EXCEPTION);
        queue_frame(FR_REPLY);
        settle();
        program_request(8'd3, 8'h7F, 16'h8000, 16'd7);
        queue_frame(FR_EXCEPTION);
        settle();
        program_request(8'd4, 8'hFF, 16'h0100, 16'd3);
        queue_frame(FR_EXCEPTION);
        queue_frame(FR_WRONG_FUNCTION);
        settle();

        // Random phases: new request, a batch of frames, drain.
        while (bytes_queued < BYTE_GOAL) begin
            logic [7:0]  fn;
            logic [15:0] qty;
            case ($urandom_range(0, 9))
                0, 1:    fn = FC_READ_COILS;
                2, 3, 4: fn = FC_READ_REGS;
                5, 6:    fn = FC_WRITE_COILS;
                7:       fn = FC_WRITE_REGS;
                default: fn = 8'($urandom);
            endcase
            qty = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            program_request(8'($urandom), fn, 16'($urandom), qty);
            repeat ($urandom_range(6, 14)) queue_frame(pick_kind());
            settle();
        end

        settle();
        if (errors == 0) begin
            $display("modbus_rtu_response_checker_unit_test: PASS");
        end else begin
            $display("modbus_rtu_response_checker_unit_test: FAIL");
        end
        $finish;
    end

endmodule
